// ===== src/dbcq_pkg.sv =====
// shared types and constants of the deduplicating bounded capture queue
`default_nettype none

package dbcq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_RESULTS = 8;
  localparam int KEY_W       = 48;
  localparam int ID_W        = 32;
  localparam int LIMIT_W     = 4;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int K_W         = $clog2(MAX_RESULTS + 1);
  localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int LIMIT_CAP   = (QUEUE_DEPTH < MAX_RESULTS) ? QUEUE_DEPTH : MAX_RESULTS;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

  typedef enum logic [1:0] {
    OP_OFFER  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_STORED         = 4'd0,
    ST_REPLACED       = 4'd1,
    ST_EVICTED        = 4'd2,
    ST_NOT_UPLOADABLE = 4'd3,
    ST_REMOVED        = 4'd4,
    ST_NOT_FOUND      = 4'd5,
    ST_DROPPED        = 4'd6,
    ST_LISTED         = 4'd7,
    ST_LIST_EMPTY     = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    SRC_HEAD,
    SRC_NEW,
    SRC_REJECT,
    SRC_MISS,
    SRC_EMPTY
  } src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DEDUP,
    S_EVICT,
    S_FINAL,
    S_REMOVE,
    S_LIST
  } state_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] access_key;
    logic             capture_valid;
    logic [ID_W-1:0]  target_id;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [ID_W-1:0]  entry_id;
    logic [KEY_W-1:0] entry_key;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic    load_item;
    logic    rotate;
    logic    pop;
    logic    push;
    logic    emit;
    status_t emit_status;
    src_t    emit_src;
    logic    emit_last;
  } dq_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [1:0]       op;
    logic             capture_valid;
    logic             key_hit;
    logic             id_hit;
    logic             evict_due;
    logic             full;
    logic             out_free;
  } dq_sts_t;

endpackage

`default_nettype wire

// ===== src/dedup_bounded_capture_queue_core.sv =====
// top level of the deduplicating bounded capture queue
`default_nettype none

// Keeps up to eight entries (48-bit key, 32-bit id) oldest first in a shift line
// that is only ever read at its head. One item is worked on at a time and the
// input stalls until its work is done. An offer with capture_valid set, a remove
// and a non-empty list each make one full pass that brings every stored entry past
// the head, one entry per cycle unless out_stall holds a due result, and rotates
// or pops it; a stored offer then evicts due entries and appends the new one. A
// rejected offer or an empty list gives one result, no pass; an unknown op, none.
// Results leave through an output register, and any cycle in which a result is due
// while that register is held by out_stall pauses the pass. No clearing pass
// follows reset.
module dedup_bounded_capture_queue_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire dbcq_pkg::in_item_t           in_item,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output dbcq_pkg::out_item_t               out_item,
  input  wire logic                         cfg_wr_en,
  input  wire logic [dbcq_pkg::LIMIT_W-1:0] cfg_wr_data
);

  dbcq_pkg::dq_cmd_t cmd;
  dbcq_pkg::dq_sts_t sts;

  dbcq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dbcq_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cmd         (cmd),
    .sts         (sts)
  );

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over an unaccepted result");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (sts.cnt != '0))
    else $error("entry dropped from an empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (sts.cnt != dbcq_pkg::CNT_W'(dbcq_pkg::QUEUE_DEPTH)))
    else $error("entry appended to a full queue");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while the first is in work");
`endif

endmodule

`default_nettype wire

// ===== src/dbcq_ctrl.sv =====
// controller state machine: sequences scans, drops, appends and result emission
`default_nettype none

module dbcq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire dbcq_pkg::dq_sts_t sts,
  output dbcq_pkg::dq_cmd_t      cmd
);

  dbcq_pkg::state_t               state_r, state_nxt;
  logic [dbcq_pkg::CNT_W-1:0]     pass_r, pass_nxt;
  logic [dbcq_pkg::K_W-1:0]       k_r, k_nxt;
  logic                           replaced_r, replaced_nxt;
  logic                           evicted_r, evicted_nxt;
  logic                           found_r, found_nxt;
  logic                           drop_room;
  logic                           pass_done;

  assign drop_room = (k_r < dbcq_pkg::K_W'(dbcq_pkg::MAX_RESULTS - 1));
  assign pass_done = (pass_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dbcq_pkg::S_IDLE;
      pass_r     <= '0;
      k_r        <= '0;
      replaced_r <= 1'b0;
      evicted_r  <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pass_r     <= pass_nxt;
      k_r        <= k_nxt;
      replaced_r <= replaced_nxt;
      evicted_r  <= evicted_nxt;
      found_r    <= found_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dbcq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = dbcq_pkg::S_DECODE;
      end
      dbcq_pkg::S_DECODE: begin
        case (sts.op)
          dbcq_pkg::OP_OFFER: begin
            if (sts.capture_valid) state_nxt = dbcq_pkg::S_DEDUP;
            else if (sts.out_free) state_nxt = dbcq_pkg::S_IDLE;
          end
          dbcq_pkg::OP_REMOVE: state_nxt = dbcq_pkg::S_REMOVE;
          dbcq_pkg::OP_LIST: begin
            if (sts.cnt != '0) state_nxt = dbcq_pkg::S_LIST;
            else if (sts.out_free) state_nxt = dbcq_pkg::S_IDLE;
          end
          default: state_nxt = dbcq_pkg::S_IDLE;
        endcase
      end
      dbcq_pkg::S_DEDUP: begin
        if (pass_done) state_nxt = dbcq_pkg::S_EVICT;
      end
      dbcq_pkg::S_EVICT: begin
        if (!(sts.evict_due && drop_room) && !sts.full) state_nxt = dbcq_pkg::S_FINAL;
      end
      dbcq_pkg::S_FINAL: begin
        if (sts.out_free) state_nxt = dbcq_pkg::S_IDLE;
      end
      dbcq_pkg::S_REMOVE: begin
        if (pass_done && (found_r || sts.out_free)) state_nxt = dbcq_pkg::S_IDLE;
      end
      dbcq_pkg::S_LIST: begin
        if (pass_done) state_nxt = dbcq_pkg::S_IDLE;
      end
      default: state_nxt = dbcq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.emit_status = dbcq_pkg::ST_STORED;
    cmd.emit_src    = dbcq_pkg::SRC_HEAD;
    in_stall = (state_r != dbcq_pkg::S_IDLE);
    case (state_r)
      dbcq_pkg::S_IDLE: begin
        cmd.load_item = in_valid;
      end
      dbcq_pkg::S_DECODE: begin
        if (sts.op == dbcq_pkg::OP_OFFER && !sts.capture_valid) begin
          cmd.emit        = sts.out_free;
          cmd.emit_status = dbcq_pkg::ST_NOT_UPLOADABLE;
          cmd.emit_src    = dbcq_pkg::SRC_REJECT;
          cmd.emit_last   = 1'b1;
        end else if (sts.op == dbcq_pkg::OP_LIST && sts.cnt == '0) begin
          cmd.emit        = sts.out_free;
          cmd.emit_status = dbcq_pkg::ST_LIST_EMPTY;
          cmd.emit_src    = dbcq_pkg::SRC_EMPTY;
          cmd.emit_last   = 1'b1;
        end
      end
      dbcq_pkg::S_DEDUP: begin
        if (!pass_done) begin
          if (sts.key_hit && drop_room) begin
            cmd.emit        = sts.out_free;
            cmd.pop         = sts.out_free;
            cmd.emit_status = dbcq_pkg::ST_DROPPED;
          end else begin
            cmd.rotate = 1'b1;
          end
        end
      end
      dbcq_pkg::S_EVICT: begin
        if (sts.evict_due && drop_room) begin
          cmd.emit        = sts.out_free;
          cmd.pop         = sts.out_free;
          cmd.emit_status = dbcq_pkg::ST_DROPPED;
        end else if (sts.full) begin
          cmd.pop = 1'b1;
        end
      end
      dbcq_pkg::S_FINAL: begin
        cmd.emit      = sts.out_free;
        cmd.push      = sts.out_free;
        cmd.emit_src  = dbcq_pkg::SRC_NEW;
        cmd.emit_last = 1'b1;
        if (evicted_r) cmd.emit_status = dbcq_pkg::ST_EVICTED;
        else if (replaced_r) cmd.emit_status = dbcq_pkg::ST_REPLACED;
        else cmd.emit_status = dbcq_pkg::ST_STORED;
      end
      dbcq_pkg::S_REMOVE: begin
        if (!pass_done) begin
          if (!found_r && sts.id_hit) begin
            cmd.emit        = sts.out_free;
            cmd.pop         = sts.out_free;
            cmd.emit_status = dbcq_pkg::ST_REMOVED;
            cmd.emit_last   = 1'b1;
          end else begin
            cmd.rotate = 1'b1;
          end
        end else if (!found_r) begin
          cmd.emit        = sts.out_free;
          cmd.emit_status = dbcq_pkg::ST_NOT_FOUND;
          cmd.emit_src    = dbcq_pkg::SRC_MISS;
          cmd.emit_last   = 1'b1;
        end
      end
      dbcq_pkg::S_LIST: begin
        if (!pass_done) begin
          if (k_r < dbcq_pkg::K_W'(dbcq_pkg::MAX_RESULTS)) begin
            cmd.emit        = sts.out_free;
            cmd.rotate      = sts.out_free;
            cmd.emit_status = dbcq_pkg::ST_LISTED;
            cmd.emit_last   = (pass_r == dbcq_pkg::CNT_W'(1)) ||
                              (k_r == dbcq_pkg::K_W'(dbcq_pkg::MAX_RESULTS - 1));
          end else begin
            cmd.rotate = 1'b1;
          end
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // scan counters and offer flags
  always_comb begin
    pass_nxt     = pass_r;
    k_nxt        = k_r;
    replaced_nxt = replaced_r;
    evicted_nxt  = evicted_r;
    found_nxt    = found_r;
    if (state_r == dbcq_pkg::S_DECODE) begin
      pass_nxt     = sts.cnt;
      k_nxt        = '0;
      replaced_nxt = 1'b0;
      evicted_nxt  = 1'b0;
      found_nxt    = 1'b0;
    end else begin
      if ((cmd.rotate || cmd.pop) && !pass_done) pass_nxt = pass_r - dbcq_pkg::CNT_W'(1);
      if (cmd.emit && !cmd.emit_last) k_nxt = k_r + dbcq_pkg::K_W'(1);
      if (cmd.emit && state_r == dbcq_pkg::S_LIST) k_nxt = k_r + dbcq_pkg::K_W'(1);
      if (cmd.pop && state_r == dbcq_pkg::S_DEDUP) replaced_nxt = 1'b1;
      if (cmd.pop && state_r == dbcq_pkg::S_EVICT) evicted_nxt = 1'b1;
      if (cmd.pop && state_r == dbcq_pkg::S_REMOVE) found_nxt = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== src/dbcq_dp.sv =====
// datapath: entry shift line, fill count, id counter, limit register and result register
`default_nettype none

module dbcq_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dbcq_pkg::in_item_t          in_item,
  input  wire logic                        cfg_wr_en,
  input  wire logic [dbcq_pkg::LIMIT_W-1:0] cfg_wr_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output dbcq_pkg::out_item_t              out_item,
  input  wire dbcq_pkg::dq_cmd_t           cmd,
  output dbcq_pkg::dq_sts_t                sts
);

  dbcq_pkg::in_item_t                item_r;
  logic [dbcq_pkg::KEY_W-1:0]        key_r   [dbcq_pkg::QUEUE_DEPTH];
  logic [dbcq_pkg::KEY_W-1:0]        key_nxt [dbcq_pkg::QUEUE_DEPTH];
  logic [dbcq_pkg::ID_W-1:0]         id_r    [dbcq_pkg::QUEUE_DEPTH];
  logic [dbcq_pkg::ID_W-1:0]         id_nxt  [dbcq_pkg::QUEUE_DEPTH];
  logic [dbcq_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [dbcq_pkg::ID_W-1:0]         next_id_r;
  logic [dbcq_pkg::LIMIT_W-1:0]      limit_r;
  logic [dbcq_pkg::LIMIT_W-1:0]      eff_limit;
  dbcq_pkg::out_item_t               out_r;
  logic                              out_valid_r;
  logic [dbcq_pkg::ID_W-1:0]         emit_id;
  logic [dbcq_pkg::KEY_W-1:0]        emit_key;

  // limit clamped to 1 .. min(depth, max results)
  always_comb begin
    if (limit_r == '0) eff_limit = dbcq_pkg::LIMIT_W'(1);
    else if (limit_r > dbcq_pkg::LIMIT_W'(dbcq_pkg::LIMIT_CAP))
      eff_limit = dbcq_pkg::LIMIT_W'(dbcq_pkg::LIMIT_CAP);
    else eff_limit = limit_r;
  end

  assign sts.cnt           = cnt_r;
  assign sts.op            = item_r.op;
  assign sts.capture_valid = item_r.capture_valid;
  assign sts.key_hit       = (key_r[0] == item_r.access_key);
  assign sts.id_hit        = (id_r[0] == item_r.target_id);
  assign sts.evict_due     = (dbcq_pkg::CMP_W'(cnt_r) >= dbcq_pkg::CMP_W'(eff_limit));
  assign sts.full          = (cnt_r == dbcq_pkg::CNT_W'(dbcq_pkg::QUEUE_DEPTH));
  assign sts.out_free      = !out_valid_r || !out_stall;

  // rotate sends the head to the tail of the filled part, pop shifts it out
  always_comb begin
    key_nxt = key_r;
    id_nxt  = id_r;
    cnt_nxt = cnt_r;
    if (cmd.rotate) begin
      for (int i = 0; i < dbcq_pkg::QUEUE_DEPTH - 1; i++) begin
        if (dbcq_pkg::CNT_W'(i + 1) == cnt_r) begin
          key_nxt[i] = key_r[0];
          id_nxt[i]  = id_r[0];
        end else begin
          key_nxt[i] = key_r[i+1];
          id_nxt[i]  = id_r[i+1];
        end
      end
      if (cnt_r == dbcq_pkg::CNT_W'(dbcq_pkg::QUEUE_DEPTH)) begin
        key_nxt[dbcq_pkg::QUEUE_DEPTH-1] = key_r[0];
        id_nxt[dbcq_pkg::QUEUE_DEPTH-1]  = id_r[0];
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < dbcq_pkg::QUEUE_DEPTH - 1; i++) begin
        key_nxt[i] = key_r[i+1];
        id_nxt[i]  = id_r[i+1];
      end
      cnt_nxt = cnt_r - dbcq_pkg::CNT_W'(1);
    end else if (cmd.push) begin
      key_nxt[cnt_r[dbcq_pkg::IDX_W-1:0]] = item_r.access_key;
      id_nxt[cnt_r[dbcq_pkg::IDX_W-1:0]]  = next_id_r;
      cnt_nxt = cnt_r + dbcq_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd.emit_src)
      dbcq_pkg::SRC_HEAD: begin
        emit_id  = id_r[0];
        emit_key = key_r[0];
      end
      dbcq_pkg::SRC_NEW: begin
        emit_id  = next_id_r;
        emit_key = item_r.access_key;
      end
      dbcq_pkg::SRC_REJECT: begin
        emit_id  = '0;
        emit_key = item_r.access_key;
      end
      dbcq_pkg::SRC_MISS: begin
        emit_id  = item_r.target_id;
        emit_key = '0;
      end
      default: begin
        emit_id  = '0;
        emit_key = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      next_id_r   <= '0;
      limit_r     <= dbcq_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.push) next_id_r <= next_id_r + dbcq_pkg::ID_W'(1);
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    id_r  <= id_nxt;
    if (cmd.load_item) item_r <= in_item;
    if (cmd.emit) begin
      out_r.status    <= cmd.emit_status;
      out_r.entry_id  <= emit_id;
      out_r.entry_key <= emit_key;
      out_r.last      <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire
